// ===== hw/rtl/lfu_pkg.sv =====
package lfu_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int GRP_SIZE    = 4;
    localparam int GROUPS      = MAX_ENTRIES / GRP_SIZE;
    localparam int VKEY_W      = 1 + COUNT_WIDTH + IDX_W;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [DATA_W-1:0]      t_data;

    typedef struct packed {
        logic load;
        logic update;
        logic vict;
        logic repl;
    } t_dp_cmd;

    typedef struct packed {
        logic evict;
    } t_dp_stat;

endpackage

// ===== hw/rtl/lfu_cache_table.sv =====
// LFU cache table: 16-entry fully associative key/value store, least
// frequently used replacement with least recently used tie-break.
// Input channel: i_in_valid / o_in_stall with i_func (0 get, 1 put),
// i_key, i_value. Output channel: o_out_valid / i_out_stall with
// o_found and o_read_value (-1 on a get miss and on every put).
// A transaction moves when valid is high and stall is low.
// Capacity is written through i_cfg_we / i_cfg_data while idle; values
// above 16 act as 16, 0 turns every put into a no-op.
// The key is matched at accept (state IDLE) and registered with the
// group victim winners; a get, a hit put or a fill put updates the
// entry in EXEC. A put that evicts goes on to VICT, which registers
// the victim pick, then to REPL, which replaces it. One transaction
// is in flight at a time; the input stalls while it is processed.
// The result sits in an output register; a stalled receiver holds
// the next transaction in its last step until that register frees.
// Synchronous reset clears all entries and sets capacity to 16.
module lfu_cache_table
    import lfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_func,
    input  logic [31:0]      i_key,
    input  logic [31:0]      i_value,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_found,
    output logic [31:0]      o_read_value
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lfu_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_stat       (stat),
        .o_found      (o_found),
        .o_read_value (o_read_value)
    );

endmodule

// ===== hw/rtl/lfu_ctrl.sv =====
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_VICT = 2'd2;
    localparam logic [1:0] S_REPL = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       emit;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        emit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.evict) begin
                    n_state = S_VICT;
                end else if (out_free) begin
                    o_cmd.update = 1'b1;
                    emit         = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_VICT: begin
                o_cmd.vict = 1'b1;
                n_state    = S_REPL;
            end
            S_REPL: begin
                if (out_free) begin
                    o_cmd.repl = 1'b1;
                    emit       = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (r_out_valid && i_out_stall) || emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/lfu_datapath.sv =====
module lfu_datapath
    import lfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  t_dp_cmd          i_cmd,
    input  logic             i_func,
    input  t_data            i_key,
    input  t_data            i_value,
    output t_dp_stat         o_stat,
    output logic             o_found,
    output t_data            o_read_value
);

    logic [CAP_W-1:0]   r_cap;
    logic [IDX_W:0]     r_nvalid;
    logic [MAX_ENTRIES-1:0] r_valid;
    t_data              r_ekey  [MAX_ENTRIES];
    t_data              r_eval  [MAX_ENTRIES];
    t_count             r_cnt   [MAX_ENTRIES];
    t_idx               r_rank  [MAX_ENTRIES];

    logic               r_func;
    t_data              r_key;
    t_data              r_value;
    logic               r_found;
    t_idx               r_hit_idx;
    t_idx               r_free_idx;
    logic [VKEY_W-1:0]  r_gkey [GROUPS];
    t_idx               r_gidx [GROUPS];
    t_idx               r_vic_idx;
    logic               r_found_out;
    t_data              r_rdval;

    logic               hit_any;
    t_idx               hit_idx;
    t_idx               free_idx;
    logic [VKEY_W-1:0]  gkey [GROUPS];
    t_idx               gidx [GROUPS];
    t_idx               vic_idx;
    logic [CAP_W-1:0]   eff_cap;
    logic               cap_zero;
    logic               do_touch;
    logic               do_insert;
    t_idx               tgt;
    logic [IDX_W:0]     thr;

    function automatic logic [VKEY_W-1:0] vkey(input logic v, input t_count c, input t_idx r);
        return {~v, c, ~r};
    endfunction

    // Key match and free-slot search on the incoming transaction.
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_valid[i] && r_ekey[i] == i_key) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Victim tree, first level: minimum of each group of four.
    always_comb begin
        logic [VKEY_W-1:0] k;
        for (int g = 0; g < GROUPS; g++) begin
            gkey[g] = vkey(r_valid[g*GRP_SIZE], r_cnt[g*GRP_SIZE], r_rank[g*GRP_SIZE]);
            gidx[g] = IDX_W'(g * GRP_SIZE);
            for (int j = 1; j < GRP_SIZE; j++) begin
                k = vkey(r_valid[g*GRP_SIZE+j], r_cnt[g*GRP_SIZE+j], r_rank[g*GRP_SIZE+j]);
                if (k < gkey[g]) begin
                    gkey[g] = k;
                    gidx[g] = IDX_W'(g * GRP_SIZE + j);
                end
            end
        end
    end

    // Victim tree, second level over registered group winners.
    always_comb begin
        logic [VKEY_W-1:0] best;
        best    = r_gkey[0];
        vic_idx = r_gidx[0];
        for (int g = 1; g < GROUPS; g++) begin
            if (r_gkey[g] < best) begin
                best    = r_gkey[g];
                vic_idx = r_gidx[g];
            end
        end
    end

    assign eff_cap  = (r_cap > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : r_cap;
    assign cap_zero = (eff_cap == '0);

    assign o_stat.evict = (r_func == FUNC_PUT) && !r_found && !cap_zero
                          && ({{(CAP_W-IDX_W-1){1'b0}}, r_nvalid} >= eff_cap);

    always_comb begin
        do_insert = i_cmd.repl
                    || (i_cmd.update && !r_found && r_func == FUNC_PUT && !cap_zero);
        do_touch  = do_insert
                    || (i_cmd.update && r_found && (r_func == FUNC_GET || !cap_zero));
        if (i_cmd.repl) begin
            tgt = r_vic_idx;
        end else if (r_found) begin
            tgt = r_hit_idx;
        end else begin
            tgt = r_free_idx;
        end
        if (!r_found && !i_cmd.repl) begin
            thr = (IDX_W+1)'(MAX_ENTRIES);
        end else begin
            thr = {1'b0, r_rank[tgt]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_nvalid <= '0;
            r_valid  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (do_insert) begin
                r_valid[tgt] <= 1'b1;
                if (!i_cmd.repl) begin
                    r_nvalid <= r_nvalid + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_key      <= i_key;
            r_value    <= i_value;
            r_found    <= hit_any;
            r_hit_idx  <= hit_idx;
            r_free_idx <= free_idx;
            for (int g = 0; g < GROUPS; g++) begin
                r_gkey[g] <= gkey[g];
                r_gidx[g] <= gidx[g];
            end
        end
        if (i_cmd.vict) begin
            r_vic_idx <= vic_idx;
        end
        if (do_touch) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_valid[i] && IDX_W'(i) != tgt && {1'b0, r_rank[i]} < thr) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            r_rank[tgt] <= '0;
            if (do_insert) begin
                r_cnt[tgt]  <= COUNT_WIDTH'(1);
                r_ekey[tgt] <= r_key;
            end else if (r_cnt[tgt] != '1) begin
                r_cnt[tgt] <= r_cnt[tgt] + 1'b1;
            end
            if (r_func == FUNC_PUT) begin
                r_eval[tgt] <= r_value;
            end
        end
        if (i_cmd.update || i_cmd.repl) begin
            r_found_out <= r_found;
            r_rdval     <= (r_func == FUNC_GET && r_found) ? r_eval[r_hit_idx] : '1;
        end
    end

    assign o_found      = r_found_out;
    assign o_read_value = r_rdval;

endmodule

// ===== dv/tb_lfu_cache_table.sv =====
module tb_lfu_cache_table;
    import lfu_pkg::*;

    localparam int          WDOG_LIMIT = 2000;
    localparam int          POOL_SIZE  = 20;
    localparam int          PHASES     = 10;
    localparam int          PHASE_TXNS = 100;
    localparam t_data       MISS       = '1;
    localparam logic [31:0] HOT_REPS   = 32'd20;

    typedef enum logic {ROW_TXN, ROW_CAP} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        func;
        logic [31:0] key;
        logic [31:0] value;     // capacity on ROW_CAP rows
        logic [31:0] reps;
        logic        typed;
        logic        exp_found;
        logic [31:0] exp_value;
    } t_dir_row;

    typedef struct packed {
        logic  found;
        t_data rd;
    } t_lookup;

    localparam int DIR_ROWS = 30;

    // Heat two entries, check victim choice by use count, then vary the capacity.
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ROW_TXN, FUNC_GET, 32'h0000_0000, 32'h0000_0000, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_CAP, FUNC_GET, 32'h0000_0000, 32'd2,         32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h8000_0000, 32'h0000_0000, HOT_REPS, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, HOT_REPS, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h8000_0000, 32'h0000_0000, 32'd1, 1'b1, 1'b1,
          32'h7FFF_FFFF},
        '{ROW_TXN, FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h8000_0000, 32'h0000_0000, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_CAP, FUNC_GET, 32'h0000_0000, 32'd31,        32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h7FFF_FFFF, 32'h0000_0000, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 1'b1, 1'b1, MISS},
        '{ROW_TXN, FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1, 1'b1, 1'b1,
          32'h8000_0000},
        '{ROW_TXN, FUNC_GET, 32'h0000_0000, 32'h0000_0000, 32'd1, 1'b1, 1'b1,
          32'hFFFF_FFFF},
        '{ROW_CAP, FUNC_GET, 32'h0000_0000, 32'd3,         32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h0000_0001, 32'h1234_5678, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_CAP, FUNC_GET, 32'h0000_0000, 32'd0,         32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h0000_0000, 32'h5555_5555, 32'd1, 1'b1, 1'b1, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h0000_0002, 32'h0000_0001, 32'd1, 1'b1, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h0000_0000, 32'h0000_0000, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h0000_0002, 32'h0000_0000, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_CAP, FUNC_GET, 32'h0000_0000, 32'd1,         32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h0000_0002, 32'hDEAD_BEEF, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h0000_0001, 32'h0000_0000, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_CAP, FUNC_GET, 32'h0000_0000, 32'd16,        32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_PUT, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'd1, 1'b0, 1'b0, MISS},
        '{ROW_TXN, FUNC_GET, 32'h5A5A_A5A5, 32'h0000_0000, 32'd1, 1'b0, 1'b0, MISS}
    };

    logic [CAP_W-1:0] phase_cap [PHASES] = '{
        5'd16, 5'd4, 5'd31, 5'd0, 5'd1, 5'd2, 5'd17, 5'd8, 5'd3, 5'd16
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CAP_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             i_func      = FUNC_GET;
    logic [31:0]      i_key       = '0;
    logic [31:0]      i_value     = '0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic             o_found;
    logic [31:0]      o_read_value;

    lfu_cache_table u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_read_value (o_read_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cache state as predicted
    logic [CAP_W-1:0] cfg_capacity = CAP_RESET;
    logic             slot_valid [MAX_ENTRIES];
    t_data            slot_key   [MAX_ENTRIES];
    t_data            slot_val   [MAX_ENTRIES];
    t_count           slot_cnt   [MAX_ENTRIES];
    int               slot_rank  [MAX_ENTRIES];

    t_lookup lookup_q [$];
    t_lookup rx_want;
    t_data   key_pool [POOL_SIZE];

    bit idle_en  = 1'b1;
    bit offering = 1'b0;
    int rx_wait  = 0;
    int rx_hold  = 0;
    int wdog     = 0;
    int mismatches = 0;
    int n_get = 0, n_put = 0, n_hit = 0, n_cap = 0;

    function automatic void touch_slot(input int e);
        int i;
        int r;
        r = slot_rank[e];
        for (i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i] && slot_rank[i] < r)
                slot_rank[i]++;
        slot_rank[e] = 0;
        if (slot_cnt[e] != '1)
            slot_cnt[e]++;
    endfunction

    function automatic void lfu_predict(input logic func, input t_data key, input t_data val,
                                        output logic found, output t_data rd);
        int i, hit, slot, nvalid, eff_cap, r;
        hit     = -1;
        slot    = -1;
        nvalid  = 0;
        eff_cap = (cfg_capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_capacity);
        for (i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_valid[i]) begin
                nvalid++;
                if (slot_key[i] == key)
                    hit = i;
            end
        end
        found = (hit >= 0);
        rd    = MISS;
        if (func == FUNC_GET) begin
            if (hit >= 0) begin
                touch_slot(hit);
                rd = slot_val[hit];
            end
            return;
        end
        if (eff_cap == 0)
            return;
        if (hit >= 0) begin
            slot_val[hit] = val;
            touch_slot(hit);
            return;
        end
        if (nvalid >= eff_cap) begin
            // lowest count, least recent on ties
            for (i = 0; i < MAX_ENTRIES; i++)
                if (slot_valid[i] && (slot < 0 || slot_cnt[i] < slot_cnt[slot] ||
                    (slot_cnt[i] == slot_cnt[slot] && slot_rank[i] > slot_rank[slot])))
                    slot = i;
            r = slot_rank[slot];
            slot_valid[slot] = 1'b0;
            for (i = 0; i < MAX_ENTRIES; i++)
                if (slot_valid[i] && slot_rank[i] > r)
                    slot_rank[i]--;
        end else begin
            for (i = 0; i < MAX_ENTRIES; i++)
                if (!slot_valid[i] && slot < 0)
                    slot = i;
        end
        for (i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i])
                slot_rank[i]++;
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_val[slot]   = val;
        slot_cnt[slot]   = 1;
        slot_rank[slot]  = 0;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic send_item(input logic func, input t_data key, input t_data val,
                             input logic typed, input logic ef, input t_data ev);
        int      gap;
        t_lookup want;
        gap = idle_en ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            if (offering) begin
                i_in_valid <= 1'b0;
                offering = 1'b0;
                i_func   <= 1'($urandom);
                i_key    <= $urandom;
                i_value  <= $urandom;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        offering = 1'b1;
        i_func   <= func;
        i_key    <= key;
        i_value  <= val;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        lfu_predict(func, key, val, want.found, want.rd);
        if (typed) begin
            want.found = ef;
            want.rd    = ev;
        end
        lookup_q.push_back(want);
        if (func == FUNC_GET)
            n_get++;
        else
            n_put++;
        if (want.found)
            n_hit++;
    endtask

    task automatic send_random();
        logic  func;
        t_data key;
        func = ($urandom_range(0, 99) < 45) ? FUNC_PUT : FUNC_GET;
        key  = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE-1)];
        send_item(func, key, $urandom, 1'b0, 1'b0, MISS);
    endtask

    task automatic wait_idle();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (lookup_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] c);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_capacity = c;
        n_cap++;
    endtask

    // result side: check against the oldest prediction, random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (lookup_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: found=%0b value=%h",
                                        o_found, o_read_value));
            end else begin
                rx_want = lookup_q.pop_front();
                if (o_found !== rx_want.found || o_read_value !== rx_want.rd)
                    flag_mismatch($sformatf(
                        "result mismatch: expected found=%0b value=%h, got found=%0b value=%h",
                        rx_want.found, rx_want.rd, o_found, o_read_value));
            end
            rx_wait = idle_en ? $urandom_range(0, 14) : 0;
        end else if (o_out_valid === 1'b1 && rx_wait > 0) begin
            rx_wait--;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (rx_wait > 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall))
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int i, p, n;
        bit saved_idle;
        for (i = 0; i < MAX_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_val[i]   = '0;
            slot_cnt[i]   = '0;
            slot_rank[i]  = 0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CAP) begin
                set_capacity(dir_tab[r].value[CAP_W-1:0]);
            end else begin
                idle_en = (dir_tab[r].reps == 1);
                repeat (dir_tab[r].reps)
                    send_item(dir_tab[r].func, dir_tab[r].key, dir_tab[r].value,
                              dir_tab[r].typed, dir_tab[r].exp_found, dir_tab[r].exp_value);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            set_capacity((p == PHASES-1) ? CAP_W'($urandom_range(0, 31)) : phase_cap[p]);
            idle_en = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_TXNS; n++) begin
                if (p == 2 && n == 40) begin
                    // back-pressure: result side holds while input keeps offering
                    saved_idle = idle_en;
                    idle_en = 1'b0;
                    rx_hold = 150;
                    repeat (12) send_random();
                    idle_en = saved_idle;
                end
                if (p == 5 && n == 55)
                    wait_idle();
                send_random();
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("covered %0d transactions: %0d get, %0d put, %0d hits, %0d capacity writes",
                 n_get + n_put, n_get, n_put, n_hit, n_cap);
        $display("incl. capacity 0, above 16 and below fill, long output hold, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
